### src/ltar_pkg.sv
// Package for the link trend anomaly and risk core.
// Holds widths, risk constants, controller states and lane control type.
// No dependencies.
package ltar_pkg;

    localparam int DATA_W        = 19;
    localparam int WINDOW_DEF    = 60;
    localparam int NUM_SLOTS_DEF = 16;
    localparam int SLOT_IN_W     = 4;
    localparam int LAT_W         = 18;
    localparam int SIG_W         = 13;
    localparam int LOSS_W        = 11;
    localparam int PROB_W        = 13;
    localparam int SIGMA_W       = 8;
    localparam int SIGMA2_W      = 2 * SIGMA_W;

    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 8'd48;
    localparam logic               CFG_SIGMA   = 1'b0;

    // risk terms, all in units of 1/16 of the sample scale
    localparam int T_W = 20;
    localparam logic [LAT_W-1:0]  LAT_KNEE      = 18'd3200;
    localparam logic [LOSS_W-1:0] LOSS_KNEE     = 11'd160;
    localparam logic [T_W-1:0]    LOSS_GAIN     = 20'd12;
    localparam logic [T_W-1:0]    SIG_GAIN      = 20'd15;
    localparam int                SIG_KNEE      = 1600;
    localparam logic [T_W-1:0]    SLOPE_PENALTY = 20'd1152;
    localparam logic [T_W-1:0]    T_FULL        = 20'd19200;
    localparam logic [PROB_W-1:0] PROB_ONE      = 13'd4096;

    // floor(x / 75) as (x * RECIP_M) >> RECIP_SH, exact for x below 2^25
    localparam int                RECIP_SH = 29;
    localparam int                RECIP_W  = 23;
    localparam logic [RECIP_W-1:0] RECIP_M = 23'd7158279;

    // cycles from the last window read until every result register is settled
    localparam int DRAIN_CYCLES = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clr;
    } lane_ctrl_t;

endpackage

### src/ltar_lane.sv
// One channel lane: sample window memory, running sums and deviation test.
// Depends on ltar_pkg.
module ltar_lane
    import ltar_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int ADDR_W   = $clog2(WINDOW * NUM_SLOTS),
    localparam int CNT_W    = $clog2(WINDOW + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               ctrl,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    input  logic [CNT_W-1:0]         n,
    input  logic [SIGMA2_W-1:0]      sigma2,
    output logic signed [DATA_W-1:0] rd_q,
    output logic                     rd_q_vld,
    output logic                     flag
);

    localparam int DEPTH  = WINDOW * NUM_SLOTS;
    localparam int S_W    = DATA_W + CNT_W;
    localparam int Q_W    = 2 * DATA_W - 1 + CNT_W;
    localparam int NQ_W   = Q_W + CNT_W;
    localparam int SS_W   = 2 * S_W;
    localparam int VAR_W  = SS_W + 1;
    localparam int NX_W   = DATA_W + CNT_W + 1;
    localparam int D_W    = NX_W + 1;
    localparam int VN_W   = VAR_W - 1 + CNT_W;
    localparam int LHS_W  = 2 * D_W + CNT_W;
    localparam int RHS_W  = VN_W + SIGMA2_W;
    localparam int CMP_W  = ((LHS_W + 8 > RHS_W) ? LHS_W + 8 : RHS_W) + 1;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [S_W-1:0]    s_reg;
    logic [Q_W-1:0]           q_reg;
    logic [NQ_W-1:0]          nq_reg;
    logic [SS_W-1:0]          ss_reg;
    logic signed [NX_W-1:0]   nx_reg;
    logic signed [S_W-1:0]    s1_reg;
    logic signed [VAR_W-1:0]  var_reg;
    logic [D_W-1:0]           ad_reg;
    logic [2*D_W-1:0]         ad2_reg;
    logic [VN_W-1:0]          vn_reg;
    logic                     vpos_reg;
    logic [LHS_W-1:0]         lhs_reg;
    logic [RHS_W-1:0]         rhs_reg;
    logic                     flag_reg;
    logic signed [D_W-1:0]    d;
    logic signed [2*DATA_W-1:0] sq;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_q_vld <= 1'b0;
        end
        else
        begin
            rd_q_vld <= ctrl.rd_en;
        end
    end

    assign sq = rd_q * rd_q;

    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            s_reg <= '0;
            q_reg <= '0;
        end
        else if (rd_q_vld)
        begin
            s_reg <= s_reg + S_W'(rd_q);
            q_reg <= q_reg + Q_W'(unsigned'(sq));
        end
    end

    assign d = D_W'(nx_reg) - D_W'(s1_reg);

    // settle over a chain of one-multiplier stages once the sums hold
    always_ff @(posedge clk)
    begin
        nq_reg   <= NQ_W'(n) * NQ_W'(q_reg);
        ss_reg   <= unsigned'(SS_W'(s_reg) * SS_W'(s_reg));
        nx_reg   <= $signed({1'b0, n}) * NX_W'(wr_data);
        s1_reg   <= s_reg;
        var_reg  <= $signed({1'b0, nq_reg}) - $signed({1'b0, ss_reg});
        ad_reg   <= d[D_W-1] ? D_W'(-d) : D_W'(d);
        ad2_reg  <= (2*D_W)'(ad_reg) * (2*D_W)'(ad_reg);
        vn_reg   <= VN_W'(var_reg[VAR_W-2:0]) * VN_W'(n);
        vpos_reg <= (var_reg > 0);
        lhs_reg  <= LHS_W'(ad2_reg) * LHS_W'(n - 1'b1);
        rhs_reg  <= RHS_W'(vn_reg) * RHS_W'(sigma2);
        flag_reg <= (n >= CNT_W'(2)) && vpos_reg &&
                    ({CMP_W'(lhs_reg), 8'b0} > {8'b0, CMP_W'(rhs_reg)});
    end

    assign flag = flag_reg;

endmodule

### src/ltar_trend.sv
// Regression slope sign test on the signal window.
// Depends on ltar_pkg; fed by the read data of the signal lane.
module ltar_trend
    import ltar_pkg::*;
#(
    parameter int WINDOW  = WINDOW_DEF,
    localparam int CNT_W  = $clog2(WINDOW + 1)
)
(
    input  logic                     clk,
    input  logic                     clr,
    input  logic                     vld,
    input  logic signed [DATA_W-1:0] y,
    input  logic [CNT_W-1:0]         n,
    output logic                     falling
);

    localparam int W_W   = CNT_W + 2;
    localparam int NUM_W = DATA_W + W_W + CNT_W;
    localparam int DEN_W = 3 * CNT_W;

    logic [CNT_W-1:0]         k_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     falling_reg;
    logic signed [W_W-1:0]    w;
    logic signed [NUM_W-1:0]  thr;

    // centered regression weight 2k - (n - 1)
    assign w   = $signed({1'b0, k_reg, 1'b0}) - $signed(W_W'(n - 1'b1));
    assign thr = -$signed({{(NUM_W-DEN_W-3){1'b0}}, den_reg, 3'b000});

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            k_reg   <= '0;
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (vld)
        begin
            k_reg   <= k_reg + 1'b1;
            num_reg <= num_reg + NUM_W'(w) * NUM_W'(y);
            den_reg <= den_reg + DEN_W'(unsigned'((2*W_W)'(w) * (2*W_W)'(w)));
        end
        falling_reg <= (n >= CNT_W'(2)) && (num_reg < thr);
    end

    assign falling = falling_reg;

endmodule

### src/ltar_merge.sv
// Merge stage: ORs the lane flags and forms the failure probability.
// Depends on ltar_pkg.
module ltar_merge
    import ltar_pkg::*;
(
    input  logic                     clk,
    input  logic [LAT_W-1:0]         lat,
    input  logic signed [SIG_W-1:0]  sig,
    input  logic [LOSS_W-1:0]        loss,
    input  logic                     falling,
    input  logic [2:0]               lane_flags,
    output logic                     anomaly,
    output logic [PROB_W-1:0]        prob
);

    localparam int P_W = T_W + RECIP_W;

    logic [T_W-1:0]    a;
    logic [T_W-1:0]    b;
    logic [T_W-1:0]    c;
    logic signed [SIG_W:0] neg_g;
    logic [T_W-1:0]    t_reg;
    logic [P_W-1:0]    prod_reg;
    logic              full_reg;
    logic [PROB_W-1:0] prob_reg;

    assign neg_g = -$signed({sig[SIG_W-1], sig});
    assign a = (lat > LAT_KNEE) ? T_W'(lat - LAT_KNEE) : '0;
    assign b = (loss > LOSS_KNEE) ? LOSS_GAIN * T_W'(loss - LOSS_KNEE) : '0;
    assign c = (neg_g > (SIG_W+1)'(SIG_KNEE)) ?
               SIG_GAIN * T_W'(neg_g - (SIG_W+1)'(SIG_KNEE)) : '0;

    always_ff @(posedge clk)
    begin
        t_reg    <= a + b + c + (falling ? SLOPE_PENALTY : '0);
        full_reg <= (t_reg >= T_FULL);
        prod_reg <= P_W'({t_reg, 4'b0}) * P_W'(RECIP_M);
        prob_reg <= full_reg ? PROB_ONE : PROB_W'(prod_reg >> RECIP_SH);
    end

    assign anomaly = |lane_flags;
    assign prob    = prob_reg;

endmodule

### src/link_trend_anomaly_risk_core.sv
// Top level of the link trend anomaly and risk core.
// Depends on ltar_pkg, ltar_lane, ltar_trend and ltar_merge.
//
// Each request names a slot and brings latency, signal and loss samples.
// The request is written into the slot's window, then the window is read
// back one entry per cycle into three channel lanes working side by side
// (running sum and sum of squares each, plus the slope sums on the signal
// lane); a short multiplier chain per lane settles the deviation test and
// the merge stage ORs the flags and forms the failure probability. A request
// passes through accept, write, one window read per entry of the filled
// window (set by the single read port of each window memory), a drain of
// the multiplier chains and the load of the output register before the
// next request is accepted.
// One request is in work at a time; a finished result waits in the output
// register and the next request is accepted while it is held. Window memory
// contents are not cleared; only the filled part of a window is ever read.
// anomaly_sigma is at byte address 0, units of 1/16 standard deviation.
module link_trend_anomaly_risk_core
    import ltar_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SLOT_IN_W-1:0]    sat_slot,
    input  logic [LAT_W-1:0]        latency_sample,
    input  logic signed [SIG_W-1:0] signal_sample,
    input  logic [LOSS_W-1:0]       loss_sample,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    dev_alarm,
    output logic [PROB_W-1:0]       risk_level
);

    localparam int ADDR_W  = $clog2(WINDOW * NUM_SLOTS);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WAIT_W  = $clog2(DRAIN_CYCLES);
    localparam int SLOT_IN = 1 << SLOT_IN_W;

    state_t state_reg, state_next;

    logic [SIGMA_W-1:0]   sigma_reg;
    logic [SIGMA2_W-1:0]  sigma2_reg;
    logic [SLOT_W-1:0]    slot_lut [SLOT_IN];
    logic [CNT_W-1:0]     fill_reg [NUM_SLOTS];
    logic [IDX_W-1:0]     wp_reg   [NUM_SLOTS];

    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [LAT_W-1:0]     lat_reg, lat_next;
    logic signed [SIG_W-1:0] sig_reg, sig_next;
    logic [LOSS_W-1:0]    loss_reg, loss_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [WAIT_W-1:0]    wait_reg, wait_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 anomaly_reg;
    logic [PROB_W-1:0]    prob_out_reg;

    logic [CNT_W-1:0]     fill_cur;
    logic [IDX_W-1:0]     wp_cur;
    logic [IDX_W-1:0]     wp_adv;
    logic [CNT_W-1:0]     fill_adv;
    logic                 load_out;
    lane_ctrl_t           ctrl;

    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic signed [DATA_W-1:0] lane_data [3];
    logic signed [DATA_W-1:0] lane_q    [3];
    logic [2:0]           lane_q_vld;
    logic [2:0]           lane_flags;
    logic                 falling;
    logic                 anomaly;
    logic [PROB_W-1:0]    prob;

    // slot numbers fold onto the slots modulo the slot count
    for (genvar g = 0; g < SLOT_IN; g++)
    begin : g_slot_lut
        assign slot_lut[g] = SLOT_W'(g % NUM_SLOTS);
    end

    // configuration port: zero-wait writes, reads return the register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_SIGMA) ? {{(32-SIGMA_W){1'b0}}, sigma_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == CFG_SIGMA)
        begin
            sigma_reg <= pwdata[SIGMA_W-1:0];
        end
    end

    // hold sigma squared in a register so it never chains into the lane multiply
    always_ff @(posedge clk)
    begin
        sigma2_reg <= SIGMA2_W'(sigma_reg) * SIGMA2_W'(sigma_reg);
    end

    assign fill_cur = fill_reg[slot_reg];
    assign wp_cur   = wp_reg[slot_reg];
    assign wp_adv   = (wp_cur == IDX_W'(WINDOW - 1)) ? '0 : wp_cur + 1'b1;
    assign fill_adv = (fill_cur < CNT_W'(WINDOW)) ? fill_cur + 1'b1 : CNT_W'(WINDOW);
    assign wr_addr  = base_reg + ADDR_W'(wp_cur);
    assign rd_addr  = base_reg + ADDR_W'(rd_idx_reg);
    assign load_out = (state_reg == ST_DONE) && !(out_valid_reg && out_stall);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        base_next      = base_reg;
        lat_next       = lat_reg;
        sig_next       = sig_reg;
        loss_next      = loss_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rd_idx_next    = rd_idx_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    slot_next  = slot_lut[sat_slot];
                    base_next  = ADDR_W'(slot_lut[sat_slot] * WINDOW);
                    lat_next   = latency_sample;
                    sig_next   = signal_sample;
                    loss_next  = loss_sample;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // store the new samples and start the window walk at the oldest entry
                ctrl.wr_en  = 1'b1;
                ctrl.clr    = 1'b1;
                n_next      = fill_adv;
                k_next      = '0;
                rd_idx_next = (fill_adv == CNT_W'(WINDOW)) ? wp_adv : '0;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                ctrl.rd_en  = 1'b1;
                k_next      = k_reg + 1'b1;
                rd_idx_next = (rd_idx_reg == IDX_W'(WINDOW - 1)) ? '0 : rd_idx_reg + 1'b1;
                if (k_reg == CNT_W'(n_reg - 1'b1))
                begin
                    wait_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WAIT_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            wait_reg      <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            wait_reg      <= wait_next;
            if (ctrl.wr_en)
            begin
                fill_reg[slot_reg] <= fill_adv;
                wp_reg[slot_reg]   <= wp_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        base_reg   <= base_next;
        lat_reg    <= lat_next;
        sig_reg    <= sig_next;
        loss_reg   <= loss_next;
        n_reg      <= n_next;
        rd_idx_reg <= rd_idx_next;
        if (load_out)
        begin
            anomaly_reg  <= anomaly;
            prob_out_reg <= prob;
        end
    end

    assign lane_data[0] = DATA_W'(lat_reg);
    assign lane_data[1] = DATA_W'(sig_reg);
    assign lane_data[2] = DATA_W'(loss_reg);

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        ltar_lane #(
            .WINDOW    (WINDOW),
            .NUM_SLOTS (NUM_SLOTS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_addr  (wr_addr),
            .wr_data  (lane_data[c]),
            .rd_addr  (rd_addr),
            .n        (n_reg),
            .sigma2   (sigma2_reg),
            .rd_q     (lane_q[c]),
            .rd_q_vld (lane_q_vld[c]),
            .flag     (lane_flags[c])
        );
    end

    ltar_trend #(
        .WINDOW (WINDOW)
    ) u_trend (
        .clk     (clk),
        .clr     (ctrl.clr),
        .vld     (lane_q_vld[1]),
        .y       (lane_q[1]),
        .n       (n_reg),
        .falling (falling)
    );

    ltar_merge u_merge (
        .clk        (clk),
        .lat        (lat_reg),
        .sig        (sig_reg),
        .loss       (loss_reg),
        .falling    (falling),
        .lane_flags (lane_flags),
        .anomaly    (anomaly),
        .prob       (prob)
    );

    assign out_valid  = out_valid_reg;
    assign dev_alarm  = anomaly_reg;
    assign risk_level = prob_out_reg;

    // window walk never issues more reads than the window holds
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (k_reg < n_reg))
        else $error("window walk ran past fill count");

    // a written slot always has a nonzero fill count afterward
    a_fill_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (fill_reg[slot_reg] != '0))
        else $error("fill count not advanced");

    // a result loaded from the done state is presented in the next cycle
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");

endmodule
